[hdl/xalu_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xalu_pkg : shared types and codes for the x86 integer ALU
// Operation codes, operand sizes, beat payloads and sequencer states.
// ---------------------------------------------------------------------------
package xalu_pkg;

   localparam int unsigned DataW = 64;
   localparam int unsigned SrcW  = 32;
   localparam int unsigned CntW  = 7;

   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_ADC  = 5'd1;
   localparam logic [4:0] OP_SUB  = 5'd2;
   localparam logic [4:0] OP_SBB  = 5'd3;
   localparam logic [4:0] OP_MUL  = 5'd4;
   localparam logic [4:0] OP_IMUL = 5'd5;
   localparam logic [4:0] OP_DIV  = 5'd6;
   localparam logic [4:0] OP_IDIV = 5'd7;
   localparam logic [4:0] OP_MOD  = 5'd8;
   localparam logic [4:0] OP_IMOD = 5'd9;
   localparam logic [4:0] OP_AND  = 5'd10;
   localparam logic [4:0] OP_XOR  = 5'd11;
   localparam logic [4:0] OP_OR   = 5'd12;
   localparam logic [4:0] OP_SHL  = 5'd13;
   localparam logic [4:0] OP_SHR  = 5'd14;
   localparam logic [4:0] OP_SAR  = 5'd15;
   localparam logic [4:0] OP_SAL  = 5'd16;

   localparam logic [1:0] SZ_8    = 2'd0;
   localparam logic [1:0] SZ_16   = 2'd1;
   localparam logic [1:0] SZ_32   = 2'd2;
   localparam logic [1:0] SZ_RSVD = 2'd3;

   typedef struct packed {
      logic [4:0]       mode;
      logic [SrcW-1:0]  src_operand;
      logic [DataW-1:0] dest_operand;
      logic [1:0]       size_code;
   } req_type;

   typedef struct packed {
      logic [DataW-1:0] result_value;
      logic             carry_flag;
      logic             parity_flag;
      logic             zero_flag;
      logic             sign_flag;
      logic             overflow_flag;
      logic             divide_error;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

endpackage

[hdl/x86_integer_alu_with_flags_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// x86_integer_alu_with_flags_top : bit-serial x86 ALU with stored flags
// The result beat comes from the one-bit-per-cycle shift/add/subtract
// datapath loop, for operand widths w = 8, 16, 32.
// One item at a time: a new request is accepted only after the result
// beat has left and the sequencer is idle again.
// Reset: synchronous, active high; clears flags and the sequencer.
// ---------------------------------------------------------------------------
// The loop runs 2w steps for every op, so add/logic/shift use the same
// counter: add/logic act in the low w steps, shifts in the first count steps.
module x86_integer_alu_with_flags_top
   import xalu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [4:0]  flags_ff, flags_in;
   req_type     req_ff;
   logic [6:0]  w;
   logic [5:0]  wt, wt2;                 // top bit index at w and at 2w
   logic [DataW-1:0] acc_ff, acc_in;     // product hi/lo, remainder, add/logic result
   logic [DataW-1:0] opa_ff, opa_in;     // serial operand a / shifted value / quotient
   logic [SrcW:0]    opb_ff, opb_in;     // operand b (magnitude for signed divide)
   logic        c_ff, c_in;              // serial carry
   logic        nn_ff, nn_in, nd_ff, nd_in;
   rsp_type     rsp_ff, rsp_in;

   logic accept, deliver;
   assign accept  = req_valid && !req_stall;
   assign deliver = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_data  = rsp_ff;

   always_comb begin
      case (req_ff.size_code)
         SZ_8:    w = 7'd8;
         SZ_16:   w = 7'd16;
         default: w = 7'd32;
      endcase
      wt  = 6'(w - 7'd1);
      wt2 = 6'((w << 1) - 7'd1);
   end

   function automatic logic [DataW-1:0] msk(input logic [6:0] n);
      msk = (n >= 7'd64) ? '1 : ((64'd1 << n) - 64'd1);
   endfunction

   function automatic logic [DataW-1:0] sx(input logic [DataW-1:0] x, input logic [6:0] n);
      logic [DataW-1:0] m;
      logic [5:0]       tb;
      m = msk(n);
      tb = 6'(n - 7'd1);
      sx = (x[tb]) ? (x | ~m) : (x & m);
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RUN;
         ST_RUN:  if (cnt_ff == '0) state_in = ST_DONE;
         ST_DONE: if (deliver) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath: one bit per cycle
   logic [DataW-1:0] a_m, b_m, n_mag, dw;
   logic [SrcW:0]    diff;
   logic             ab, bb, sbit;
   logic [6:0]       sh;
   logic [CntW-1:0]  step;
   always_comb begin
      a_m  = req_ff.dest_operand & msk(w);
      b_m  = {32'd0, req_ff.src_operand} & msk(w);
      n_mag = '0;
      dw   = '0;
      diff = '0;
      ab = 1'b0; bb = 1'b0; sbit = 1'b0;
      sh = {2'd0, req_ff.src_operand[4:0]};
      step = (CntW'(w) << 1) - cnt_ff;   // bit index of current step
      acc_in = acc_ff; opa_in = opa_ff; opb_in = opb_ff; c_in = c_ff;
      nn_in = nn_ff; nd_in = nd_ff;
      cnt_in = cnt_ff;
      if (state_ff == ST_IDLE) begin
         cnt_in = '0;
      end
      if (state_ff == ST_RUN && cnt_ff == (CntW'(w) << 1) + CntW'(1)) begin
         // load step
         cnt_in = cnt_ff - CntW'(1);
         acc_in = '0;
         c_in = 1'b0;
         case (req_ff.mode)
            OP_ADC, OP_SBB: c_in = flags_ff[0];
            default: c_in = 1'b0;
         endcase
         case (req_ff.mode)
            OP_IMUL: begin
               opa_in = sx(a_m, w) & msk(w << 1);
               opb_in = 33'(sx(b_m, w) & msk(w));
               nn_in = 1'b0; nd_in = 1'b0;
            end
            OP_IDIV, OP_IMOD: begin
               dw = sx(req_ff.dest_operand & msk(w << 1), w << 1);
               nn_in = dw[63];
               nd_in = b_m[wt];
               n_mag = dw[63] ? (64'd0 - dw) : dw;
               opa_in = n_mag;
               opb_in = nd_in ? 33'((64'd0 - sx(b_m, w)) & 64'hFFFFFFFF)
                              : 33'(b_m);
               if (nd_in && b_m[wt] && (b_m & (msk(w) >> 1)) == '0)
                  opb_in = {1'b0, 32'(b_m)};
            end
            OP_DIV, OP_MOD: begin
               opa_in = req_ff.dest_operand & msk(w << 1);
               opb_in = 33'(b_m);
            end
            default: begin
               opa_in = a_m;
               opb_in = 33'(b_m);
            end
         endcase
      end else if (state_ff == ST_RUN && cnt_ff != '0) begin
         cnt_in = cnt_ff - CntW'(1);
         case (req_ff.mode)
            OP_MUL, OP_IMUL: begin
               // shift-add: a doubles, added per set b bit; IMUL subtracts at sign bit
               opa_in = (opa_ff << 1) & msk(w << 1);
               if (opb_ff[step[4:0]] && step < CntW'(w)) begin
                  if (req_ff.mode == OP_IMUL && step == CntW'(w) - CntW'(1))
                     acc_in = (acc_ff - opa_ff) & msk(w << 1);
                  else
                     acc_in = (acc_ff + opa_ff) & msk(w << 1);
               end
            end
            OP_DIV, OP_MOD, OP_IDIV, OP_IMOD: begin
               // restoring division: remainder in acc, quotient into opa
               diff = {acc_ff[31:0], opa_ff[wt2]} - opb_ff;
               if (!diff[32]) begin
                  acc_in = {32'd0, diff[31:0]};
                  opa_in = ((opa_ff << 1) | 64'd1) & msk(w << 1);
               end else begin
                  acc_in = {32'd0, acc_ff[30:0], opa_ff[wt2]};
                  opa_in = (opa_ff << 1) & msk(w << 1);
               end
            end
            OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_AND, OP_XOR, OP_OR: begin
               if (step < CntW'(w)) begin
                  ab = opa_ff[step[5:0]];
                  bb = opb_ff[step[4:0]];
                  case (req_ff.mode)
                     OP_ADD, OP_ADC: begin
                        sbit = ab ^ bb ^ c_ff;
                        c_in = (ab & bb) | (c_ff & (ab ^ bb));
                     end
                     OP_SUB, OP_SBB: begin
                        sbit = ab ^ bb ^ c_ff;
                        c_in = (~ab & bb) | (c_ff & ~(ab ^ bb));
                     end
                     OP_AND:  sbit = ab & bb;
                     OP_XOR:  sbit = ab ^ bb;
                     default: sbit = ab | bb;
                  endcase
                  acc_in[step[5:0]] = sbit;
               end
            end
            default: begin
               // shifts: one position per step while count remains
               if (step < CntW'(sh)) begin
                  case (req_ff.mode)
                     OP_SHR: begin
                        c_in = opa_ff[0];
                        opa_in = opa_ff >> 1;
                     end
                     OP_SAR: begin
                        c_in = opa_ff[0];
                        opa_in = ((opa_ff >> 1) | ({63'd0, opa_ff[wt]} << (w - 7'd1)))
                                 & msk(w);
                     end
                     default: begin
                        c_in = opa_ff[wt];
                        opa_in = (opa_ff << 1) & msk(w);
                     end
                  endcase
               end
            end
         endcase
      end
      if (accept) cnt_in = (CntW'(7'd16) << req_data.size_code) + CntW'(1);
      if (accept && req_data.size_code == SZ_RSVD) cnt_in = CntW'(65);
   end

   // result and flags, formed once the loop ends
   logic [DataW-1:0] r, q, rm;
   logic pf, zf, sf;
   logic [6:0] sh_w;
   always_comb begin
      flags_in = flags_ff;
      rsp_in = rsp_ff;
      r = '0;
      q = opa_ff & msk(w);
      rm = acc_ff & msk(w);
      sh_w = {2'd0, req_ff.src_operand[4:0]};
      case (req_ff.mode)
         OP_MUL, OP_IMUL, OP_ADD, OP_ADC, OP_SUB, OP_SBB,
         OP_AND, OP_XOR, OP_OR: r = acc_ff;
         OP_DIV:  r = q;
         OP_MOD:  r = rm;
         OP_IDIV: r = ((nn_ff != nd_ff) ? (64'd0 - q) : q) & msk(w);
         OP_IMOD: r = (nn_ff ? (64'd0 - rm) : rm) & msk(w);
         OP_SHL, OP_SHR, OP_SAR, OP_SAL: r = opa_ff;
         default: r = '0;
      endcase
      pf = ~^r[7:0];
      zf = ((r & msk(w)) == '0);
      sf = r[wt];
      if (state_ff == ST_RUN && cnt_ff == '0) begin
         rsp_in.divide_error = 1'b0;
         case (req_ff.mode)
            OP_ADD, OP_ADC: begin
               flags_in = {(~(a_m[wt] ^ b_m[wt])) & (a_m[wt] ^ r[wt]),
                           sf, zf, pf, c_ff};
            end
            OP_SUB, OP_SBB: begin
               flags_in = {(a_m[wt] ^ b_m[wt]) & (a_m[wt] ^ r[wt]),
                           sf, zf, pf, c_ff};
            end
            OP_MUL: begin
               flags_in[0] = (r >> w) != '0;
               flags_in[4] = flags_in[0];
            end
            OP_IMUL: begin
               flags_in[0] = sx(r, w) != sx(r, w << 1);
               flags_in[4] = flags_in[0];
            end
            OP_DIV, OP_MOD, OP_IDIV, OP_IMOD: begin
               if (b_m == '0) begin
                  r = '0;
                  rsp_in.divide_error = 1'b1;
               end
            end
            OP_AND, OP_XOR, OP_OR: flags_in = {1'b0, sf, zf, pf, 1'b0};
            OP_SHL, OP_SHR, OP_SAR, OP_SAL: begin
               if (sh_w != '0) begin
                  flags_in[0] = (req_ff.mode == OP_SAR || sh_w <= w) ? c_ff : 1'b0;
                  flags_in[3:1] = {sf, zf, pf};
                  if (sh_w == 7'd1) begin
                     case (req_ff.mode)
                        OP_SHR:  flags_in[4] = a_m[wt];
                        OP_SAR:  flags_in[4] = 1'b0;
                        default: flags_in[4] = c_ff ^ r[wt];
                     endcase
                  end
               end
            end
            default: ;
         endcase
         rsp_in.result_value  = r;
         rsp_in.carry_flag    = flags_in[0];
         rsp_in.parity_flag   = flags_in[1];
         rsp_in.zero_flag     = flags_in[2];
         rsp_in.sign_flag     = flags_in[3];
         rsp_in.overflow_flag = flags_in[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flags_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         flags_ff <= flags_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      c_ff   <= c_in;
      nn_ff  <= nn_in;
      nd_ff  <= nd_in;
      rsp_ff <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !accept) else $error("accept while busy");
   a_rsp_after_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_RUN)) else $error("result out of order");
   a_flags_hold_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && $past(state_ff == ST_IDLE)) |-> $stable(flags_ff))
      else $error("flags moved while idle");
`endif

endmodule
